@@ rtl/ptlr_pkg.sv @@
package ptlr_pkg;

    localparam int COORD_FRAC     = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int GAIN_W         = 17;

    typedef logic signed [31:0] word_t;
    typedef logic signed [32:0] diff_t;
    typedef logic [30:0]        mag_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROT_W   = 3'd0,
        REG_ROT_X   = 3'd1,
        REG_ROT_Y   = 3'd2,
        REG_ROT_Z   = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } cfg_reg_t;

    // one point after pose transform and line direction normalization
    typedef struct packed {
        word_t [2:0]       lp;
        diff_t [2:0]       d;
        mag_t  [2:0]       mag;
        logic  [2:0]       neg;
        logic [GAIN_W-1:0] gain;
        logic              want_jac;
        logic              degen;
    } item_t;

    typedef struct packed {
        word_t       residual;
        word_t [2:0] jac_rot;
        word_t [2:0] jac_move;
    } row_t;

    function automatic word_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ rtl/ptlr_front.sv @@
module ptlr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ptlr_pkg::word_t [2:0]           point,
    input  ptlr_pkg::word_t [2:0]           line_a,
    input  ptlr_pkg::word_t [2:0]           line_b,
    input  logic [ptlr_pkg::GAIN_W-1:0]     gain,
    input  logic                            want_jacobian,
    output logic                            item_valid,
    input  logic                            item_ready,
    output ptlr_pkg::item_t                 item
);

    localparam logic [1:0] SETTLE = 2'd3;
    localparam logic signed [39:0] ONE40 = 40'sd1073741824;

    ptlr_pkg::word_t rot_reg [4];
    ptlr_pkg::word_t shift_reg [3];
    logic [1:0]      wait_reg;

    logic signed [63:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [63:0] wx_reg, wy_reg, wz_reg;
    ptlr_pkg::word_t    rm_c [3][3];
    ptlr_pkg::word_t    rm_reg [3][3];

    logic [5:0] fv_reg;
    logic       f_adv;
    logic       accept;

    // S1
    ptlr_pkg::word_t p1_reg [3];
    ptlr_pkg::word_t la1_reg [3];
    ptlr_pkg::word_t lb1_reg [3];
    logic [ptlr_pkg::GAIN_W-1:0] g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;
    logic wj1_reg, wj2_reg, wj3_reg, wj4_reg, wj5_reg;
    // S2
    logic signed [63:0] rp_reg [3][3];
    ptlr_pkg::diff_t    e2_reg [3];
    ptlr_pkg::word_t    la2_reg [3];
    // S3
    ptlr_pkg::word_t lp3_reg [3];
    ptlr_pkg::word_t la3_reg [3];
    logic [31:0]     mag3_reg [3];
    logic [2:0]      neg3_reg;
    // S4
    ptlr_pkg::diff_t d4_reg [3];
    ptlr_pkg::word_t lp4_reg [3];
    logic [31:0]     mag4_reg [3];
    logic [2:0]      neg4_reg;
    logic [31:0]     m4_reg;
    // S5
    ptlr_pkg::diff_t d5_reg [3];
    ptlr_pkg::word_t lp5_reg [3];
    logic [31:0]     mag5_reg [3];
    logic [2:0]      neg5_reg;
    logic [4:0]      sh5_reg;
    logic            big5_reg, deg5_reg;
    // S6
    ptlr_pkg::item_t item_reg;

    logic [31:0] m_c;
    logic [4:0]  sh_c;
    logic [31:0] up_c [3];

    function automatic logic signed [39:0] q30(input logic signed [63:0] v);
        return 40'(signed'(v[63:30]));
    endfunction

    function automatic ptlr_pkg::word_t clamp_q(input logic signed [39:0] v);
        if (v > 40'sd1073741824) begin
            return 32'sd1073741824;
        end else if (v < -40'sd1073741824) begin
            return -32'sd1073741824;
        end else begin
            return v[31:0];
        end
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]   <= 32'sd1073741824;
            rot_reg[1]   <= '0;
            rot_reg[2]   <= '0;
            rot_reg[3]   <= '0;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
            wait_reg     <= SETTLE;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (ptlr_pkg::cfg_reg_t'(cfg_index))
                    ptlr_pkg::REG_ROT_W:   rot_reg[0]   <= cfg_data;
                    ptlr_pkg::REG_ROT_X:   rot_reg[1]   <= cfg_data;
                    ptlr_pkg::REG_ROT_Y:   rot_reg[2]   <= cfg_data;
                    ptlr_pkg::REG_ROT_Z:   rot_reg[3]   <= cfg_data;
                    ptlr_pkg::REG_SHIFT_X: shift_reg[0] <= cfg_data;
                    ptlr_pkg::REG_SHIFT_Y: shift_reg[1] <= cfg_data;
                    ptlr_pkg::REG_SHIFT_Z: shift_reg[2] <= cfg_data;
                    default: ;
                endcase
                wait_reg <= SETTLE;
            end
            else if (wait_reg != 2'd0)
            begin
                wait_reg <= wait_reg - 2'd1;
            end
        end
    end

    // rm_reg follows the quaternions via the product registers
    always_ff @(posedge clk)
    begin
        xx_reg <= rot_reg[1] * rot_reg[1];
        yy_reg <= rot_reg[2] * rot_reg[2];
        zz_reg <= rot_reg[3] * rot_reg[3];
        xy_reg <= rot_reg[1] * rot_reg[2];
        xz_reg <= rot_reg[1] * rot_reg[3];
        yz_reg <= rot_reg[2] * rot_reg[3];
        wx_reg <= rot_reg[0] * rot_reg[1];
        wy_reg <= rot_reg[0] * rot_reg[2];
        wz_reg <= rot_reg[0] * rot_reg[3];
        rm_reg <= rm_c;
    end

    always_comb
    begin
        rm_c[0][0] = clamp_q(ONE40 - ((q30(yy_reg) + q30(zz_reg)) <<< 1));
        rm_c[0][1] = clamp_q((q30(xy_reg) - q30(wz_reg)) <<< 1);
        rm_c[0][2] = clamp_q((q30(xz_reg) + q30(wy_reg)) <<< 1);
        rm_c[1][0] = clamp_q((q30(xy_reg) + q30(wz_reg)) <<< 1);
        rm_c[1][1] = clamp_q(ONE40 - ((q30(xx_reg) + q30(zz_reg)) <<< 1));
        rm_c[1][2] = clamp_q((q30(yz_reg) - q30(wx_reg)) <<< 1);
        rm_c[2][0] = clamp_q((q30(xz_reg) - q30(wy_reg)) <<< 1);
        rm_c[2][1] = clamp_q((q30(yz_reg) + q30(wx_reg)) <<< 1);
        rm_c[2][2] = clamp_q(ONE40 - ((q30(xx_reg) + q30(yy_reg)) <<< 1));
    end

    assign f_adv    = !(fv_reg[5] && !item_ready);
    assign in_ready = f_adv && (wait_reg == 2'd0);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (f_adv)
        begin
            fv_reg <= {fv_reg[4:0], accept};
        end
    end

    always_comb
    begin
        m_c = mag3_reg[0];
        if (mag3_reg[1] > m_c)
        begin
            m_c = mag3_reg[1];
        end
        if (mag3_reg[2] > m_c)
        begin
            m_c = mag3_reg[2];
        end
        // leading one search below bit 31
        sh_c = '0;
        for (int b = 0; b < 31; b++)
        begin
            if (m4_reg[b])
            begin
                sh_c = 5'(30 - b);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            up_c[i] = mag5_reg[i] << sh5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i]  <= point[i];
                la1_reg[i] <= line_a[i];
                lb1_reg[i] <= line_b[i];

                for (int j = 0; j < 3; j++)
                begin
                    rp_reg[i][j] <= rm_reg[i][j] * p1_reg[j];
                end
                e2_reg[i]  <= ptlr_pkg::diff_t'(la1_reg[i]) - ptlr_pkg::diff_t'(lb1_reg[i]);
                la2_reg[i] <= la1_reg[i];

                lp3_reg[i]  <= ptlr_pkg::sat32(64'(signed'(
                               (66'(rp_reg[i][0]) + 66'(rp_reg[i][1]) + 66'(rp_reg[i][2]))
                               >>> 30)) + 64'(shift_reg[i]));
                la3_reg[i]  <= la2_reg[i];
                mag3_reg[i] <= e2_reg[i][32] ? 32'(-e2_reg[i]) : 32'(e2_reg[i]);
                neg3_reg[i] <= e2_reg[i][32];

                d4_reg[i]   <= ptlr_pkg::diff_t'(lp3_reg[i]) - ptlr_pkg::diff_t'(la3_reg[i]);
                lp4_reg[i]  <= lp3_reg[i];
                mag4_reg[i] <= mag3_reg[i];

                d5_reg[i]   <= d4_reg[i];
                lp5_reg[i]  <= lp4_reg[i];
                mag5_reg[i] <= mag4_reg[i];

                item_reg.lp[i]  <= lp5_reg[i];
                item_reg.d[i]   <= d5_reg[i];
                item_reg.mag[i] <= big5_reg ? 31'(mag5_reg[i] >> 1) : up_c[i][30:0];
            end
            g1_reg   <= gain;
            wj1_reg  <= want_jacobian;
            g2_reg   <= g1_reg;
            wj2_reg  <= wj1_reg;
            g3_reg   <= g2_reg;
            wj3_reg  <= wj2_reg;
            g4_reg   <= g3_reg;
            wj4_reg  <= wj3_reg;
            g5_reg   <= g4_reg;
            wj5_reg  <= wj4_reg;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            m4_reg   <= m_c;
            sh5_reg  <= sh_c;
            big5_reg <= m4_reg[31];
            deg5_reg <= (m4_reg == 32'd0);

            item_reg.neg      <= neg5_reg;
            item_reg.gain     <= g5_reg;
            item_reg.want_jac <= wj5_reg;
            item_reg.degen    <= deg5_reg;
        end
    end

    assign item_valid = fv_reg[5];
    assign item       = item_reg;

endmodule

@@ rtl/ptlr_queue.sv @@
module ptlr_queue #(
    parameter int DEPTH = ptlr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ptlr_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ptlr_pkg::item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptlr_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              push, pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/ptlr_back.sv @@
module ptlr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  ptlr_pkg::item_t item,
    output logic            out_valid,
    input  logic            out_ready,
    output ptlr_pkg::row_t  row,
    output logic            degenerate,
    output logic            last_row
);

    localparam int SQ_STEPS   = 32;
    localparam int DIV_STEPS  = 31;
    localparam int K_SUM      = 2;
    localparam int K_DIV      = K_SUM + SQ_STEPS + 1;
    localparam int K_U        = K_DIV + DIV_STEPS + 1;
    localparam int K_PROD     = K_U + 1;
    localparam int K_MIX      = K_PROD + 1;
    localparam int MOVE_SHIFT = 46 - ptlr_pkg::COORD_FRAC;
    localparam logic [1:0] ROW_LAST = 2'd2;

    ptlr_pkg::item_t item_pipe_reg [K_MIX+1];
    logic [K_MIX:0]  bv_reg;
    logic            b_adv;

    logic [61:0] sq_reg [3];
    logic [63:0] sx_reg [SQ_STEPS+1];
    logic [63:0] sr_reg [SQ_STEPS+1];
    logic [31:0] n_reg [DIV_STEPS+1];
    logic [31:0] rem_reg [3][DIV_STEPS+1];
    logic [30:0] q_reg [3][DIV_STEPS+1];

    ptlr_pkg::word_t    u_reg [3];
    ptlr_pkg::word_t    u_p_reg [3];
    ptlr_pkg::word_t    u_m_reg [3];
    logic signed [63:0] cp_reg [6];
    logic signed [63:0] lpu_reg [3][3];
    logic signed [35:0] c_reg [3];
    logic signed [35:0] mm_reg [3][3];

    logic signed [35:0] c_c [3];
    logic signed [35:0] mm_c [3][3];
    logic signed [32:0] tt_c [3][3];
    logic signed [17:0] gs_c;
    ptlr_pkg::row_t     rows_c [3];

    ptlr_pkg::row_t rows_reg [3];
    logic           deg_reg;
    logic [1:0]     row_reg;
    logic           hold_valid_reg;

    function automatic ptlr_pkg::word_t gmul(input logic signed [35:0] v,
                                             input logic signed [17:0] g);
        logic signed [53:0] p;
        p = v * g;
        return ptlr_pkg::sat32(64'(signed'(p[53:16])));
    endfunction

    function automatic ptlr_pkg::word_t tmul(input logic signed [32:0] v,
                                             input logic signed [17:0] g);
        logic signed [50:0] p;
        p = v * g;
        return ptlr_pkg::sat32(64'(p >>> MOVE_SHIFT));
    endfunction

    // the whole back pipe moves while the row register can take an item
    assign b_adv      = !hold_valid_reg || (out_ready && row_reg == ROW_LAST);
    assign item_ready = b_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg         <= '0;
            hold_valid_reg <= 1'b0;
            row_reg        <= '0;
        end
        else if (b_adv)
        begin
            bv_reg         <= {bv_reg[K_MIX-1:0], item_valid};
            hold_valid_reg <= bv_reg[K_MIX];
            row_reg        <= '0;
        end
        else if (out_ready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            item_pipe_reg[0] <= item;
            for (int k = 1; k <= K_MIX; k++)
            begin
                item_pipe_reg[k] <= item_pipe_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= item_pipe_reg[0].mag[i] * item_pipe_reg[0].mag[i];
            end
            sx_reg[0] <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            sr_reg[0] <= '0;
            n_reg[0]  <= sr_reg[SQ_STEPS][31:0];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div_load
        always_ff @(posedge clk)
        begin
            if (b_adv)
            begin
                rem_reg[i][0] <= 32'(item_pipe_reg[K_DIV-1].mag[i] >> 1);
                q_reg[i][0]   <= '0;
            end
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [63:0] bit_c;
        logic [64:0] trial_c;
        assign bit_c   = 64'd1 << (62 - 2 * j);
        assign trial_c = {1'b0, sr_reg[j]} + {1'b0, bit_c};
        always_ff @(posedge clk)
        begin
            if (b_adv)
            begin
                if ({1'b0, sx_reg[j]} >= trial_c)
                begin
                    sx_reg[j+1] <= sx_reg[j] - trial_c[63:0];
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + bit_c;
                end
                else
                begin
                    sx_reg[j+1] <= sx_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
            end
        end
    end

    // restoring division mag * 2^30 / n, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (b_adv)
            begin
                n_reg[j+1] <= n_reg[j];
            end
        end
        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic        nb_c;
            logic [32:0] sh_c;
            logic [32:0] df_c;
            logic        ge_c;
            assign nb_c = (j == 0) ? item_pipe_reg[K_DIV].mag[i][0] : 1'b0;
            assign sh_c = {rem_reg[i][j], nb_c};
            assign ge_c = (sh_c >= {1'b0, n_reg[j]});
            assign df_c = sh_c - {1'b0, n_reg[j]};
            always_ff @(posedge clk)
            begin
                if (b_adv)
                begin
                    rem_reg[i][j+1] <= ge_c ? df_c[31:0] : sh_c[31:0];
                    q_reg[i][j+1]   <= {q_reg[i][j][29:0], ge_c};
                end
            end
        end
    end

    always_comb
    begin
        c_c[0] = 36'(((66'(cp_reg[0]) - 66'(cp_reg[1])) >>> 30));
        c_c[1] = 36'(((66'(cp_reg[2]) - 66'(cp_reg[3])) >>> 30));
        c_c[2] = 36'(((66'(cp_reg[4]) - 66'(cp_reg[5])) >>> 30));
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (i == j)
                begin
                    mm_c[i][j] = 36'((-(66'(lpu_reg[(i+1)%3][(i+1)%3])
                                      + 66'(lpu_reg[(i+2)%3][(i+2)%3]))) >>> 30);
                end
                else
                begin
                    mm_c[i][j] = 36'(signed'(lpu_reg[i][j][63:30]));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= item_pipe_reg[K_U-1].neg[i]
                          ? -ptlr_pkg::word_t'({1'b0, q_reg[i][DIV_STEPS]})
                          : ptlr_pkg::word_t'({1'b0, q_reg[i][DIV_STEPS]});
                u_p_reg[i] <= u_reg[i];
                u_m_reg[i] <= u_p_reg[i];
                for (int j = 0; j < 3; j++)
                begin
                    lpu_reg[i][j] <= item_pipe_reg[K_U].lp[i] * u_reg[j];
                    mm_reg[i][j]  <= mm_c[i][j];
                end
                c_reg[i] <= c_c[i];
            end
            cp_reg[0] <= item_pipe_reg[K_U].d[1] * u_reg[2];
            cp_reg[1] <= item_pipe_reg[K_U].d[2] * u_reg[1];
            cp_reg[2] <= item_pipe_reg[K_U].d[2] * u_reg[0];
            cp_reg[3] <= item_pipe_reg[K_U].d[0] * u_reg[2];
            cp_reg[4] <= item_pipe_reg[K_U].d[0] * u_reg[1];
            cp_reg[5] <= item_pipe_reg[K_U].d[1] * u_reg[0];
        end
    end

    always_comb
    begin
        gs_c = signed'({1'b0, item_pipe_reg[K_MIX].gain});
        tt_c[0][0] = '0;
        tt_c[0][1] = 33'(u_m_reg[2]);
        tt_c[0][2] = -33'(u_m_reg[1]);
        tt_c[1][0] = -33'(u_m_reg[2]);
        tt_c[1][1] = '0;
        tt_c[1][2] = 33'(u_m_reg[0]);
        tt_c[2][0] = 33'(u_m_reg[1]);
        tt_c[2][1] = -33'(u_m_reg[0]);
        tt_c[2][2] = '0;
        for (int i = 0; i < 3; i++)
        begin
            rows_c[i].residual = item_pipe_reg[K_MIX].degen ? '0 : gmul(c_reg[i], gs_c);
            for (int j = 0; j < 3; j++)
            begin
                if (item_pipe_reg[K_MIX].degen || !item_pipe_reg[K_MIX].want_jac)
                begin
                    rows_c[i].jac_rot[j]  = '0;
                    rows_c[i].jac_move[j] = '0;
                end
                else
                begin
                    rows_c[i].jac_rot[j]  = gmul(mm_reg[i][j], gs_c);
                    rows_c[i].jac_move[j] = tmul(tt_c[i][j], gs_c);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            rows_reg <= rows_c;
            deg_reg  <= item_pipe_reg[K_MIX].degen;
        end
    end

    assign out_valid  = hold_valid_reg;
    assign row        = rows_reg[row_reg];
    assign degenerate = deg_reg;
    assign last_row   = (row_reg == ROW_LAST);

endmodule

@@ rtl/point_to_line_residual_jacobian_unit.sv @@
// Result rows: the first row of a point is followed by the other two
// rows from the row register while out_ready is high.
// The three-row output register takes a new point when empty or its last row goes.
// Reset: pose returns to identity rotation and zero translation, pipes empty;
// in_ready stays low after reset and any register write until wait_reg is 0.
module point_to_line_residual_jacobian_unit #(
    parameter int QUEUE_DEPTH = ptlr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic signed [31:0]               point_z,
    input  logic signed [31:0]               line_a_x,
    input  logic signed [31:0]               line_a_y,
    input  logic signed [31:0]               line_a_z,
    input  logic signed [31:0]               line_b_x,
    input  logic signed [31:0]               line_b_y,
    input  logic signed [31:0]               line_b_z,
    input  logic [16:0]                      gain,
    input  logic                             want_jacobian,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               residual,
    output logic signed [31:0]               jac_rot_x,
    output logic signed [31:0]               jac_rot_y,
    output logic signed [31:0]               jac_rot_z,
    output logic signed [31:0]               jac_move_x,
    output logic signed [31:0]               jac_move_y,
    output logic signed [31:0]               jac_move_z,
    output logic                             degenerate,
    output logic                             last_row
);

    ptlr_pkg::word_t [2:0] point_v, line_a_v, line_b_v;
    ptlr_pkg::item_t       f_item, q_item;
    logic                  f_valid, f_ready, q_valid, q_ready;
    ptlr_pkg::row_t        row;

    assign point_v  = {point_z, point_y, point_x};
    assign line_a_v = {line_a_z, line_a_y, line_a_x};
    assign line_b_v = {line_b_z, line_b_y, line_b_x};

    ptlr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .point         (point_v),
        .line_a        (line_a_v),
        .line_b        (line_b_v),
        .gain          (gain),
        .want_jacobian (want_jacobian),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item          (f_item)
    );

    ptlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    ptlr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row        (row),
        .degenerate (degenerate),
        .last_row   (last_row)
    );

    assign residual   = row.residual;
    assign jac_rot_x  = row.jac_rot[0];
    assign jac_rot_y  = row.jac_rot[1];
    assign jac_rot_z  = row.jac_rot[2];
    assign jac_move_x = row.jac_move[0];
    assign jac_move_y = row.jac_move[1];
    assign jac_move_z = row.jac_move[2];

endmodule

@@ dv/ptlr_row_checker.sv @@
module ptlr_row_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ptlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic signed [31:0]               point_z,
    input  logic signed [31:0]               line_a_x,
    input  logic signed [31:0]               line_a_y,
    input  logic signed [31:0]               line_a_z,
    input  logic signed [31:0]               line_b_x,
    input  logic signed [31:0]               line_b_y,
    input  logic signed [31:0]               line_b_z,
    input  logic [16:0]                      gain,
    input  logic                             want_jacobian,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [31:0]               residual,
    input  logic signed [31:0]               jac_rot_x,
    input  logic signed [31:0]               jac_rot_y,
    input  logic signed [31:0]               jac_rot_z,
    input  logic signed [31:0]               jac_move_x,
    input  logic signed [31:0]               jac_move_y,
    input  logic signed [31:0]               jac_move_z,
    input  logic                             degenerate,
    input  logic                             last_row,
    output int                               errors,
    output int                               rows_pending
);

    typedef struct {
        logic signed [31:0] res;
        logic signed [31:0] jr[3];
        logic signed [31:0] jm[3];
        logic               degen;
        logic               last;
    } edge_row_t;

    logic signed [31:0] pose[7];
    edge_row_t          expected_rows[$];
    int                 row_count;

    assign rows_pending = expected_rows.size();

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint clip_unit(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned acc = 0;
        longint unsigned b = 64'h1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= acc + b)
            begin
                x -= acc + b;
                acc = (acc >> 1) + b;
            end
            else
                acc >>= 1;
            b >>= 2;
        end
        return acc;
    endfunction

    task automatic predict_edge_rows(input longint p[3], input longint la[3], input longint lb[3],
                                     input longint g, input logic wj);
        longint qw, qx, qy, qz, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        longint rm[3][3];
        longint lp[3], u[3], d[3], c[3], mm[3][3], sk[3][3], pu[3], e;
        longint unsigned mag[3], m, sum, n;
        logic neg[3];
        edge_row_t r;
        qw = longint'(pose[ptlr_pkg::REG_ROT_W]);
        qx = longint'(pose[ptlr_pkg::REG_ROT_X]);
        qy = longint'(pose[ptlr_pkg::REG_ROT_Y]);
        qz = longint'(pose[ptlr_pkg::REG_ROT_Z]);
        xx = (qx * qx) >>> 30; yy = (qy * qy) >>> 30; zz = (qz * qz) >>> 30;
        xy = (qx * qy) >>> 30; xz = (qx * qz) >>> 30; yz = (qy * qz) >>> 30;
        wx = (qw * qx) >>> 30; wy = (qw * qy) >>> 30; wz = (qw * qz) >>> 30;
        rm[0][0] = clip_unit(64'sd1073741824 - 2 * (yy + zz));
        rm[0][1] = clip_unit(2 * (xy - wz));
        rm[0][2] = clip_unit(2 * (xz + wy));
        rm[1][0] = clip_unit(2 * (xy + wz));
        rm[1][1] = clip_unit(64'sd1073741824 - 2 * (xx + zz));
        rm[1][2] = clip_unit(2 * (yz - wx));
        rm[2][0] = clip_unit(2 * (xz - wy));
        rm[2][1] = clip_unit(2 * (yz + wx));
        rm[2][2] = clip_unit(64'sd1073741824 - 2 * (xx + yy));
        for (int i = 0; i < 3; i++)
            lp[i] = longint'(clip32(((rm[i][0] * p[0] + rm[i][1] * p[1] + rm[i][2] * p[2]) >>> 30)
                                    + longint'(pose[ptlr_pkg::REG_SHIFT_X + i])));
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            e = la[i] - lb[i];
            neg[i] = e < 0;
            mag[i] = neg[i] ? -e : e;
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r.res = 0;
                for (int j = 0; j < 3; j++)
                begin
                    r.jr[j] = 0;
                    r.jm[j] = 0;
                end
                r.degen = 1'b1;
                r.last = (i == 2);
                expected_rows.push_back(r);
            end
            return;
        end
        // common power-of-two scaling of the line direction
        if (m >= (64'h1 << 31))
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        else
            while (m < (64'h1 << 30))
            begin
                m <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
        sum = 0;
        for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
        n = root_floor(sum);
        for (int i = 0; i < 3; i++)
        begin
            u[i] = longint'((mag[i] << 30) / n);
            if (neg[i]) u[i] = -u[i];
            d[i] = lp[i] - la[i];
            pu[i] = lp[i] * u[i];
        end
        c[0] = (d[1] * u[2] - d[2] * u[1]) >>> 30;
        c[1] = (d[2] * u[0] - d[0] * u[2]) >>> 30;
        c[2] = (d[0] * u[1] - d[1] * u[0]) >>> 30;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                mm[i][j] = (i == j) ? -(pu[(i + 1) % 3] + pu[(i + 2) % 3]) : lp[i] * u[j];
        sk[0][0] = 0;     sk[0][1] = u[2];  sk[0][2] = -u[1];
        sk[1][0] = -u[2]; sk[1][1] = 0;     sk[1][2] = u[0];
        sk[2][0] = u[1];  sk[2][1] = -u[0]; sk[2][2] = 0;
        for (int i = 0; i < 3; i++)
        begin
            r.res = clip32((c[i] * g) >>> 16);
            for (int j = 0; j < 3; j++)
            begin
                r.jr[j] = wj ? clip32(((mm[i][j] >>> 30) * g) >>> 16) : 32'sd0;
                r.jm[j] = wj ? clip32((sk[i][j] * g) >>> (46 - ptlr_pkg::COORD_FRAC)) : 32'sd0;
            end
            r.degen = 1'b0;
            r.last = (i == 2);
            expected_rows.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("row %0d: %s got %0d expected %0d", row_count, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++) pose[i] = 0;
            pose[ptlr_pkg::REG_ROT_W] = 32'sh40000000;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index <= ptlr_pkg::REG_SHIFT_Z)
                pose[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                predict_edge_rows('{point_x, point_y, point_z},
                                  '{line_a_x, line_a_y, line_a_z},
                                  '{line_b_x, line_b_y, line_b_z},
                                  longint'(gain), want_jacobian);
        end
    end

    initial
    begin
        errors = 0;
        row_count = 0;
    end

    always @(posedge clk)
    begin
        edge_row_t w;
        logic signed [31:0] gr[3];
        logic signed [31:0] gm[3];
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                $display("row %0d: result with nothing expected", row_count);
                errors++;
            end
            else
            begin
                w = expected_rows.pop_front();
                gr = '{jac_rot_x, jac_rot_y, jac_rot_z};
                gm = '{jac_move_x, jac_move_y, jac_move_z};
                if (residual !== w.res) report_mismatch("residual", residual, w.res);
                for (int j = 0; j < 3; j++)
                begin
                    if (gr[j] !== w.jr[j]) report_mismatch($sformatf("jac_rot[%0d]", j),
                                                           gr[j], w.jr[j]);
                    if (gm[j] !== w.jm[j]) report_mismatch($sformatf("jac_move[%0d]", j),
                                                           gm[j], w.jm[j]);
                end
                if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
                if (last_row !== w.last) report_mismatch("last_row", last_row, w.last);
            end
            row_count++;
        end
    end
endmodule

@@ dv/tb_point_to_line_residual_jacobian_unit.sv @@
module tb_point_to_line_residual_jacobian_unit;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [ptlr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
    logic signed [31:0] line_a_x = 0, line_a_y = 0, line_a_z = 0;
    logic signed [31:0] line_b_x = 0, line_b_y = 0, line_b_z = 0;
    logic [16:0] gain = '0;
    logic want_jacobian = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] residual, jac_rot_x, jac_rot_y, jac_rot_z;
    logic signed [31:0] jac_move_x, jac_move_y, jac_move_z;
    logic degenerate, last_row;
    int errors, rows_pending;
    bit calm = 0;

    always #2 clk = ~clk;

    point_to_line_residual_jacobian_unit uut (.*);
    ptlr_row_checker chk (.*);

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 16);
    endfunction

    task automatic send_point(input logic signed [31:0] c[9], input logic [16:0] g,
                              input logic wj);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        point_x <= c[0]; point_y <= c[1]; point_z <= c[2];
        line_a_x <= c[3]; line_a_y <= c[4]; line_a_z <= c[5];
        line_b_x <= c[6]; line_b_y <= c[7]; line_b_z <= c[8];
        gain <= g;
        want_jacobian <= wj;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        cfg_valid <= 0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ptlr_pkg::CFG_INDEX_W-1:0] idx, input logic [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_pose(input logic [31:0] w, x, y, z, sx, sy, sz);
        drain();
        write_reg(ptlr_pkg::REG_ROT_W, w);
        write_reg(ptlr_pkg::REG_ROT_X, x);
        write_reg(ptlr_pkg::REG_ROT_Y, y);
        write_reg(ptlr_pkg::REG_ROT_Z, z);
        write_reg(ptlr_pkg::REG_SHIFT_X, sx);
        write_reg(ptlr_pkg::REG_SHIFT_Y, sy);
        write_reg(ptlr_pkg::REG_SHIFT_Z, sz);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
            default: return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_quat();
        return $urandom_range(0, 32'h80000000) - 32'h40000000;
    endfunction

    task automatic random_points(input int count);
        logic signed [31:0] c[9];
        logic [16:0] g;
        for (int k = 0; k < count; k++)
        begin
            if (k % 15 == 0) calm = $urandom_range(0, 3) == 0;
            for (int i = 0; i < 9; i++) c[i] = rand_coord();
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
                1: c[6 + $urandom_range(0, 2)] = c[3] ^ (32'h1 << $urandom_range(0, 31));
                default: ;
            endcase
            g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 65536);
            send_point(c, g, $urandom_range(0, 3) != 0);
        end
        calm = 0;
    endtask

    localparam logic signed [31:0] MAXC = 32'sh7fffffff;
    localparam logic signed [31:0] MINC = 32'sh80000000;

    initial
    begin
        logic signed [31:0] c[9];
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, coincident line points, gain edges, jacobian off
        send_point('{0, 0, 0, 0, 0, 0, 32'sh10000, 0, 0}, 17'd65536, 1);
        send_point('{MAXC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC}, 17'd65536, 1);
        send_point('{MINC, MINC, MINC, MINC, 0, MAXC, MAXC, 0, MINC}, 17'h1ffff, 1);
        send_point('{32'sh10000, 32'sh20000, 0, 5, 6, 7, 5, 6, 7}, 17'd65536, 1);
        send_point('{MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC}, 17'd40000, 0);
        send_point('{32'sh30000, -32'sh10000, 32'sh8000, 0, 0, 0, 1, 0, 0}, 17'd0, 1);
        send_point('{32'sh30000, -32'sh10000, 32'sh8000, 0, 0, 0, 0, 0, -1}, 17'h1ffff, 1);
        send_point('{-32'sh50000, 32'sh70000, 32'sh1000, 32'sh10000, 32'sh10000, 32'sh10000,
                     -32'sh10000, 32'sh20000, 32'sh30000}, 17'd32768, 0);
        send_point('{MAXC, 0, MINC, 0, MAXC, 0, 0, MINC, 0}, 17'd65535, 1);

        set_pose(32'h00000000, 32'h40000000, 32'h00000000, 32'h00000000,
                 32'h7fffffff, 32'h80000000, 32'h00000000);
        write_reg(3'd7, 32'hffffffff);
        send_point('{MAXC, MINC, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0}, 17'd65536, 1);
        send_point('{MINC, MAXC, MINC, 0, 0, 0, -32'sh4000, 0, 32'sh4000}, 17'h1ffff, 1);
        random_points(30);

        set_pose(32'hc0000000, 32'hc0000000, 32'h40000000, 32'hc0000000,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        random_points(30);

        set_pose(32'h2d413ccd, 32'h2d413ccd, 32'h00000000, 32'h00000000,
                 32'h00018000, 32'hfffe0000, 32'h00004000);
        random_points(50);

        for (int ph = 0; ph < 3; ph++)
        begin
            set_pose(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                     rand_coord(), rand_coord(), rand_coord());
            random_points(40);
        end

        set_pose(32'h40000000, 0, 0, 0, 0, 0, 0);
        random_points(30);

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int stall;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!(out_valid && rst_n));
        end
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/ptlr_pkg.sv
rtl/ptlr_front.sv
rtl/ptlr_queue.sv
rtl/ptlr_back.sv
rtl/point_to_line_residual_jacobian_unit.sv
dv/ptlr_row_checker.sv
dv/tb_point_to_line_residual_jacobian_unit.sv
